// ===== rtl/gha_pkg.sv =====
// Shared types and constants for the generational handle allocator.
// Holds field widths, status and command codes, and the front-to-back command record.
// No dependencies.
package gha_pkg;

    localparam int SLOTS_DEF  = 1024;
    localparam int BATCH_DEF  = 16;

    localparam int IDX_W      = 10;
    localparam int GEN_W      = 32;
    localparam int CNT_W      = 5;
    localparam int ST_W       = 2;
    localparam int KIND_W     = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam int CMDQ_DEPTH = 2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_STALE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // classified command kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        logic [ST_W-1:0]  status;
        logic             last;
    } t_result;

    // handshake between the command queue and the back end
    typedef struct packed {
        logic valid;
        logic pop;
    } t_cmdq_ctl;

endpackage

// ===== rtl/gha_front.sv =====
// Front end: classifies incoming requests into commands for the back end.
// Depends on gha_pkg.
module gha_front import gha_pkg::*; #(
    parameter int MAX_SLOTS = SLOTS_DEF,
    parameter int MAX_BATCH = BATCH_DEF
) (
    input  logic             i_valid,
    input  logic             i_opcode,
    input  logic [CNT_W-1:0] i_count,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [GEN_W-1:0] i_gen,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic             out_of_range;
    logic [CNT_W-1:0] sat_count;

    assign out_of_range = (32'(i_idx) >= MAX_SLOTS);
    assign sat_count    = (32'(i_count) > MAX_BATCH) ? CNT_W'(MAX_BATCH) : i_count;

    always_comb begin
        o_cmd.count = sat_count;
        o_cmd.idx   = i_idx;
        o_cmd.gen   = i_gen;
        if (!i_opcode) begin
            o_cmd.kind = KIND_ALLOC;
        end else if (out_of_range) begin
            o_cmd.kind = KIND_RANGE;
        end else begin
            o_cmd.kind = KIND_FREE;
        end
    end

    assign o_ready = !i_q_full;
    // drop an allocate of zero handles here: it has no result
    assign o_push  = i_valid && !i_q_full && !(!i_opcode && (sat_count == '0));

endmodule

// ===== rtl/gha_cmdq.sv =====
// Short command queue between the front end and the back end.
// Depends on gha_pkg.
module gha_cmdq import gha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMDQ_DEPTH - 1);

    t_cmd              r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_QW-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_QW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/gha_back.sv =====
// Back end: sequencer over the generation table and the free-slot FIFO.
// Depends on gha_pkg.
module gha_back import gha_pkg::*; #(
    parameter int MAX_SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output t_cmdq_ctl o_ctl,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_result   o_out
);

    localparam int SW = $clog2(MAX_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);
    localparam logic [SW:0]   SLOT_CNT  = (SW+1)'(MAX_SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_AGEN = 3'd2;
    localparam logic [2:0] S_AWR  = 3'd3;
    localparam logic [2:0] S_FCHK = 3'd4;

    // table word: live flag on top of the generation
    logic [GEN_W:0]   r_gen_mem [MAX_SLOTS];
    logic [SW-1:0]    r_q_mem   [MAX_SLOTS];

    logic [2:0]       r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_left, n_left;
    logic [SW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_tail, n_tail;
    logic [SW:0]      r_qcount, n_qcount;
    logic [SW:0]      r_fresh, n_fresh;
    logic [SW-1:0]    r_slot, n_slot;
    logic [SW-1:0]    r_qrd;
    logic [GEN_W:0]   r_grd;
    logic             r_out_valid, n_out_valid;
    t_result          r_out;

    logic             gm_we, gm_re, qm_we, qm_re;
    logic [SW-1:0]    gm_waddr, gm_raddr;
    logic [GEN_W:0]   gm_wdata;
    logic [SW-1:0]    qm_wdata;
    logic             emit, ofree, in_use, a_last, free_ok;
    logic [SW-1:0]    cmd_slot;
    logic [GEN_W-1:0] next_gen;
    t_result          res;

    function automatic logic [SW-1:0] f_wrap(input logic [SW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    assign ofree    = !r_out_valid || i_out_ready;
    assign cmd_slot = SW'(r_cmd.idx);
    // slots at or above the fresh pointer were never handed out
    assign in_use   = ((SW+1)'(r_cmd.idx) < r_fresh);
    assign a_last   = (r_left == CNT_W'(1));
    assign next_gen = r_grd[GEN_W-1:0] + 1'b1;
    assign free_ok  = r_grd[GEN_W] && (r_grd[GEN_W-1:0] == r_cmd.gen)
                      && (r_qcount < SLOT_CNT);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_left      = r_left;
        n_head      = r_head;
        n_tail      = r_tail;
        n_qcount    = r_qcount;
        n_fresh     = r_fresh;
        n_slot      = r_slot;
        gm_we       = 1'b0;
        gm_re       = 1'b0;
        gm_waddr    = '0;
        gm_raddr    = '0;
        gm_wdata    = '0;
        qm_we       = 1'b0;
        qm_re       = 1'b0;
        qm_wdata    = '0;
        emit        = 1'b0;
        res         = '0;
        o_ctl.valid = i_cmd_valid;
        o_ctl.pop   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_ctl.pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_left    = i_cmd.count;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_cmd.kind)
                    KIND_RANGE: begin
                        if (ofree) begin
                            emit    = 1'b1;
                            res     = '{r_cmd.idx, r_cmd.gen, ST_RANGE, 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    KIND_FREE: begin
                        if (in_use) begin
                            gm_re    = 1'b1;
                            gm_raddr = cmd_slot;
                            n_state  = S_FCHK;
                        end else if (ofree) begin
                            emit    = 1'b1;
                            res     = '{r_cmd.idx, r_cmd.gen, ST_STALE, 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    KIND_ALLOC: begin
                        if (r_qcount != '0) begin
                            qm_re   = 1'b1;
                            n_state = S_AGEN;
                        end else if (ofree) begin
                            emit   = 1'b1;
                            n_left = r_left - 1'b1;
                            if (r_fresh < SLOT_CNT) begin
                                gm_we    = 1'b1;
                                gm_waddr = r_fresh[SW-1:0];
                                gm_wdata = {1'b1, {GEN_W{1'b0}}};
                                n_fresh  = r_fresh + 1'b1;
                                res      = '{IDX_W'(r_fresh), '0, ST_OK, a_last};
                            end else begin
                                res = '{'0, '0, ST_FULL, a_last};
                            end
                            if (a_last) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_AGEN: begin
                gm_re    = 1'b1;
                gm_raddr = r_qrd;
                n_slot   = r_qrd;
                n_state  = S_AWR;
            end
            S_AWR: begin
                if (ofree) begin
                    gm_we    = 1'b1;
                    gm_waddr = r_slot;
                    gm_wdata = {1'b1, next_gen};
                    n_head   = f_wrap(r_head);
                    n_qcount = r_qcount - 1'b1;
                    emit     = 1'b1;
                    res      = '{IDX_W'(r_slot), next_gen, ST_OK, a_last};
                    n_left   = r_left - 1'b1;
                    n_state  = a_last ? S_IDLE : S_DISP;
                end
            end
            S_FCHK: begin
                if (ofree) begin
                    if (free_ok) begin
                        gm_we    = 1'b1;
                        gm_waddr = cmd_slot;
                        gm_wdata = {1'b0, r_cmd.gen};
                        qm_we    = 1'b1;
                        qm_wdata = cmd_slot;
                        n_tail   = f_wrap(r_tail);
                        n_qcount = r_qcount + 1'b1;
                    end
                    emit    = 1'b1;
                    res     = '{r_cmd.idx, r_cmd.gen, free_ok ? ST_OK : ST_STALE, 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (gm_we) begin
            r_gen_mem[gm_waddr] <= gm_wdata;
        end
        if (gm_re) begin
            r_grd <= r_gen_mem[gm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (qm_we) begin
            r_q_mem[r_tail] <= qm_wdata;
        end
        if (qm_re) begin
            r_qrd <= r_q_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_left <= n_left;
        r_slot <= n_slot;
        if (emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_qcount    <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_qcount    <= n_qcount;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// Generational handle allocator: hands out and takes back (slot, generation) handles.
// Input requests arrive on s_axis; one result per handle leaves on m_axis, tlast on the
// final result of a request. Reset is synchronous and active low on i_clk.
//   Allocate (tuser 0): count handles (saturated to MAX_BATCH, zero gives no result).
//     A handle reuses the oldest freed slot with its generation plus one, else takes the
//     next never-used slot with generation zero, else reports out of slots.
//   Free (tuser 1): one handle; ok, stale/already free, or index out of range.
// Timing: a request passes the front end into a two-entry command queue, and
//   the back end pops it into its command register. A fresh-slot handle is emitted from
//   dispatch; a reused-slot handle goes through FIFO read, table read and table write (the
//   single-port table read-modify-write); a free reads the table, or is answered stale at
//   dispatch. The next command is popped only after the last result of the current one.
// Reset empties the free FIFO, the fresh-slot counter and both queues at once; the table
//   needs no clearing pass since entries past the fresh counter are never read.
// Stall: a result waits in the output register while m_axis_tready is low; the back end
//   holds, the command queue fills, and s_axis_tready drops only when it is full.
module generational_handle_allocator import gha_pkg::*; #(
    parameter int MAX_SLOTS = SLOTS_DEF,
    parameter int MAX_BATCH = BATCH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // count[4:0], handle_index[14:5], handle_generation[46:15], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // slot_index[9:0], slot_generation[41:10], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [ST_W-1:0]        m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int OUT_PAD_W = OUT_TDATA_W - IDX_W - GEN_W;

    logic      fe_push;
    t_cmd      fe_cmd;
    t_cmd      q_cmd;
    logic      q_full, q_empty;
    t_cmdq_ctl be_ctl;
    t_result   be_out;

    // Classify requests: saturate count, spot out-of-range frees, drop empty allocates.
    gha_front #(
        .MAX_SLOTS (MAX_SLOTS),
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .i_valid  (s_axis_tvalid),
        .i_opcode (s_axis_tuser),
        .i_count  (s_axis_tdata[CNT_W-1:0]),
        .i_idx    (s_axis_tdata[CNT_W +: IDX_W]),
        .i_gen    (s_axis_tdata[CNT_W+IDX_W +: GEN_W]),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (fe_push),
        .o_cmd    (fe_cmd)
    );

    // Decouple the front end from the back end.
    gha_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_cmd   (fe_cmd),
        .i_pop   (be_ctl.pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Carry out commands against the generation table and free FIFO.
    gha_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!q_empty),
        .o_ctl       (be_ctl),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (be_out)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, be_out.gen, be_out.idx};
    assign m_axis_tuser = be_out.status;
    assign m_axis_tlast = be_out.last;

`ifndef NO_ASSERTIONS
    // the back end takes a command only when the queue holds one
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_ctl.pop |-> be_ctl.valid)
        else $error("command popped from empty queue");

    // an out-of-slots result carries a null handle
    a_full_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (m_axis_tdata == '0))
        else $error("out-of-slots result with non-null handle");

    // a range error is the only result of its free request
    a_range_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_RANGE)) |-> m_axis_tlast)
        else $error("range error result without tlast");
`endif

endmodule

// ===== test/tb_generational_handle_allocator.sv =====
// Testbench for generational_handle_allocator: allocate and free requests go in on s_axis,
// and every handle result on m_axis is checked against a built-in predictor of the slot table.
// Depends on rtl/gha_pkg.sv and rtl/generational_handle_allocator.sv.
`timescale 1ns / 100ps

module tb_generational_handle_allocator import gha_pkg::*;;

    localparam bit OP_ALLOC = 1'b0;
    localparam bit OP_FREE  = 1'b1;

    localparam int BACKLOG_AT     = 40;    // requests sent before the long output hold
    localparam int BACKLOG_CYCLES = 400;
    localparam int PRINT_CAP      = 40;    // keep the log short if the block is badly off
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int NUM_DIRECTED   = 18;

    typedef enum int {RG_CHURN, RG_FILL, RG_REUSE} t_regime;

    // one row of the directed table; typed rows carry their single result
    typedef struct {
        bit          op;
        logic [4:0]  cnt;
        logic [9:0]  idx;
        logic [31:0] gen;
        bit          typed;
        logic [9:0]  exp_idx;
        logic [31:0] exp_gen;
        logic [1:0]  exp_st;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]        m_axis_tuser;
    logic                   m_axis_tlast;

    // predicted slot table, reuse FIFO and fresh-slot counter
    logic [GEN_W-1:0] slot_gen [SLOTS_DEF];
    bit               slot_live [SLOTS_DEF];
    logic [IDX_W-1:0] reuse_fifo [$];
    logic [10:0]      fresh_next = '0;

    // live handles and the last freed one, used to build good frees and double frees
    logic [IDX_W-1:0] live_handles [$];
    logic [IDX_W-1:0] last_freed_idx = '0;
    logic [GEN_W-1:0] last_freed_gen = '0;
    bit               have_freed = 1'b0;

    t_result          expected_handles [$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int requests_sent = 0;
    int mismatch_count = 0;
    int handles_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    logic [GEN_W-1:0] max_gen_seen = '0;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        // first allocate after reset takes slot 0 at generation 0
        '{OP_ALLOC, 5'd1,  10'd0,    32'd0,          1, 10'd0,    32'd0,          ST_OK},
        // wrong generation, then a good free, then the same free again
        '{OP_FREE,  5'd0,  10'd0,    32'd1,          1, 10'd0,    32'd1,          ST_STALE},
        '{OP_FREE,  5'd0,  10'd0,    32'd0,          1, 10'd0,    32'd0,          ST_OK},
        '{OP_FREE,  5'd0,  10'd0,    32'd0,          1, 10'd0,    32'd0,          ST_STALE},
        // zero count gives nothing back
        '{OP_ALLOC, 5'd0,  10'h3FF,  32'hFFFF_FFFF,  0, 10'd0,    32'd0,          ST_OK},
        // slot 0 comes back from the FIFO one generation up
        '{OP_ALLOC, 5'd1,  10'd0,    32'd0,          1, 10'd0,    32'd1,          ST_OK},
        // oversized count saturates to a full batch
        '{OP_ALLOC, 5'd31, 10'd0,    32'd0,          0, 10'd0,    32'd0,          ST_OK},
        '{OP_ALLOC, 5'd16, 10'h3FF,  32'hFFFF_FFFF,  0, 10'd0,    32'd0,          ST_OK},
        // never-allocated slot at the top of the range
        '{OP_FREE,  5'd31, 10'h3FF,  32'd0,          1, 10'h3FF,  32'd0,          ST_STALE},
        '{OP_FREE,  5'd0,  10'd5,    32'hFFFF_FFFF,  1, 10'd5,    32'hFFFF_FFFF,  ST_STALE},
        '{OP_FREE,  5'd0,  10'd5,    32'd0,          1, 10'd5,    32'd0,          ST_OK},
        '{OP_FREE,  5'd0,  10'd9,    32'd0,          1, 10'd9,    32'd0,          ST_OK},
        // two reused slots in FIFO order, then a fresh one
        '{OP_ALLOC, 5'd3,  10'd0,    32'd0,          0, 10'd0,    32'd0,          ST_OK},
        // old generation of a reused slot is stale
        '{OP_FREE,  5'd0,  10'd5,    32'd0,          1, 10'd5,    32'd0,          ST_STALE},
        '{OP_FREE,  5'd0,  10'd5,    32'd1,          1, 10'd5,    32'd1,          ST_OK},
        '{OP_ALLOC, 5'd17, 10'h2AA,  32'h5555_5555,  0, 10'd0,    32'd0,          ST_OK},
        '{OP_FREE,  5'h15, 10'h2AA,  32'hAAAA_AAAA,  1, 10'h2AA,  32'hAAAA_AAAA,  ST_STALE},
        '{OP_ALLOC, 5'd2,  10'h155,  32'h0F0F_F0F0,  0, 10'd0,    32'd0,          ST_OK}
    };

    generational_handle_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Work out the handles one accepted request gives, and advance the predicted state.
    task automatic compute_handle_results(input bit op, input logic [4:0] cnt,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [GEN_W-1:0] gen);
        int want;
        int i;
        logic [IDX_W-1:0] slot;
        t_result r;
        if (op == OP_ALLOC) begin
            want = (cnt > BATCH_DEF) ? BATCH_DEF : int'(cnt);
            for (i = 0; i < want; i++) begin
                if (reuse_fifo.size() != 0) begin
                    // oldest freed slot first, one generation up (wraps at 32 bits)
                    slot = reuse_fifo[0];
                    reuse_fifo.delete(0);
                    slot_gen[slot] = slot_gen[slot] + 1'b1;
                    slot_live[slot] = 1'b1;
                    live_handles.insert(live_handles.size(), slot);
                    r.idx = slot;
                    r.gen = slot_gen[slot];
                    r.status = ST_OK;
                end else if (fresh_next < SLOTS_DEF) begin
                    slot = fresh_next[IDX_W-1:0];
                    fresh_next = fresh_next + 1'b1;
                    slot_gen[slot] = '0;
                    slot_live[slot] = 1'b1;
                    live_handles.insert(live_handles.size(), slot);
                    r.idx = slot;
                    r.gen = '0;
                    r.status = ST_OK;
                end else begin
                    // out of slots: nothing changes
                    r.idx = '0;
                    r.gen = '0;
                    r.status = ST_FULL;
                end
                r.last = (i == want - 1);
                expected_handles.insert(expected_handles.size(), r);
            end
        end else begin
            r.idx = idx;
            r.gen = gen;
            r.last = 1'b1;
            if (idx >= SLOTS_DEF) begin
                r.status = ST_RANGE;
            end else if (!slot_live[idx] || slot_gen[idx] != gen) begin
                r.status = ST_STALE;
            end else if (reuse_fifo.size() >= SLOTS_DEF) begin
                r.status = ST_STALE;
            end else begin
                slot_live[idx] = 1'b0;
                reuse_fifo.insert(reuse_fifo.size(), idx);
                for (i = 0; i < live_handles.size(); i++) begin
                    if (live_handles[i] == idx) begin
                        live_handles.delete(i);
                        break;
                    end
                end
                last_freed_idx = idx;
                last_freed_gen = gen;
                have_freed = 1'b1;
                r.status = ST_OK;
            end
            expected_handles.insert(expected_handles.size(), r);
        end
    endtask

    // Idling modes rotate every 40 requests: none, sender idle, receiver stall, both light.
    function automatic void set_idle_mode();
        case ((requests_sent / 40) % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
            default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
        endcase
    endfunction

    // Offer one request, hold it until accepted, then predict. Called and left at a falling edge.
    task automatic offer_request(input bit op, input logic [4:0] cnt,
                                 input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen,
                                 input bit typed, input t_result fixed);
        int first;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {1'b0, gen, idx, cnt};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        first = expected_handles.size();
        compute_handle_results(op, cnt, idx, gen);
        // typed rows replace the predicted single result with the one read off by hand
        if (typed && expected_handles.size() == first + 1) begin
            fixed.last = 1'b1;
            expected_handles[first] = fixed;
        end
        requests_sent++;
        set_idle_mode();
        @(negedge i_clk);
    endtask

    // Build one random request; the regime sets the mix of allocates, good frees and noise.
    task automatic issue_random(input t_regime regime);
        int roll;
        int alloc_pct;
        int free_pct;
        int k;
        bit op;
        logic [4:0] cnt;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        roll = $urandom_range(99);
        cnt = 5'($urandom);
        idx = IDX_W'($urandom);
        gen = $urandom;
        case (regime)
            RG_CHURN: begin alloc_pct = 50; free_pct = 40; end
            RG_FILL:  begin alloc_pct = 85; free_pct = 10; end
            default:  begin alloc_pct = 30; free_pct = 58; end
        endcase
        if (roll < alloc_pct) begin
            op = OP_ALLOC;
            case (regime)
                RG_CHURN: cnt = 5'($urandom_range(6, 1));
                RG_FILL:  cnt = 5'($urandom_range(31, 12));
                default:  cnt = 5'($urandom_range(4, 1));
            endcase
        end else if (roll < alloc_pct + free_pct && live_handles.size() != 0) begin
            op = OP_FREE;
            k = $urandom_range(live_handles.size() - 1);
            idx = live_handles[k];
            gen = slot_gen[idx];
        end else begin
            // broken requests: empty batch, oversized batch, double free, wrong generation, random free
            case ($urandom_range(4))
                0: begin op = OP_ALLOC; cnt = '0; end
                1: begin op = OP_ALLOC; cnt = 5'($urandom_range(31, 17)); end
                2: begin
                    op = OP_FREE;
                    if (have_freed) begin
                        idx = last_freed_idx;
                        gen = last_freed_gen;
                    end
                end
                3: begin
                    op = OP_FREE;
                    if (live_handles.size() != 0) begin
                        k = $urandom_range(live_handles.size() - 1);
                        idx = live_handles[k];
                        gen = slot_gen[idx] ^ (32'd1 << $urandom_range(31));
                    end
                end
                default: op = OP_FREE;
            endcase
        end
        offer_request(op, cnt, idx, gen, 1'b0, '0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Check every accepted result against the oldest predicted handle.
    always @(posedge i_clk) begin : check_results
        t_result want;
        logic [IDX_W-1:0] got_idx;
        logic [GEN_W-1:0] got_gen;
        got_idx = m_axis_tdata[IDX_W-1:0];
        got_gen = m_axis_tdata[IDX_W +: GEN_W];
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (expected_handles.size() == 0) begin
                report_mismatch("result with no request outstanding, slot", got_idx, 0);
            end else begin
                want = expected_handles[0];
                expected_handles.delete(0);
                if (got_idx !== want.idx)
                    report_mismatch("slot_index", got_idx, want.idx);
                if (got_gen !== want.gen)
                    report_mismatch("slot_generation", got_gen, want.gen);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
                handles_checked++;
                status_seen[want.status]++;
                if (want.gen > max_gen_seen)
                    max_gen_seen = want.gen;
            end
        end
    end

    // Drive the output ready at falling edges; once, hold it low long enough to back up the input.
    initial begin : result_sink
        bit backlog_done;
        backlog_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!backlog_done && requests_sent >= BACKLOG_AT) begin
                backlog_done = 1'b1;
                m_axis_tready = 1'b0;
                repeat (BACKLOG_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin : stimulus
        int n;
        t_result fixed;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_idle_mode();

        // directed table
        for (n = 0; n < NUM_DIRECTED; n++) begin
            fixed.idx = directed_rows[n].exp_idx;
            fixed.gen = directed_rows[n].exp_gen;
            fixed.status = directed_rows[n].exp_st;
            fixed.last = 1'b1;
            offer_request(directed_rows[n].op, directed_rows[n].cnt, directed_rows[n].idx,
                          directed_rows[n].gen, directed_rows[n].typed, fixed);
        end

        // mixed small allocates and frees, then fill every fresh slot and run out,
        // then churn the reuse FIFO with the table full
        while (requests_sent < 110)
            issue_random(RG_CHURN);
        while (fresh_next < SLOTS_DEF)
            issue_random(RG_FILL);
        repeat (12) issue_random(RG_FILL);
        while (requests_sent < 280)
            issue_random(RG_REUSE);

        // drop valid, drain the outstanding handles, then watch for strays
        s_axis_tvalid = 1'b0;
        rx_stall_pct = 0;
        while (expected_handles.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("covered %0d requests (%0d directed), %0d handles checked, %0d slots used",
                 requests_sent, NUM_DIRECTED, handles_checked, fresh_next);
        $display("status ok %0d, stale %0d, out of slots %0d; highest generation %0d",
                 status_seen[ST_OK], status_seen[ST_STALE], status_seen[ST_FULL],
                 max_gen_seen);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d handles outstanding", expected_handles.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gha_pkg.sv
rtl/gha_front.sv
rtl/gha_cmdq.sv
rtl/gha_back.sv
rtl/generational_handle_allocator.sv
test/tb_generational_handle_allocator.sv
